[src/lru_page_replacement_assert.svh]
// Assertion macros shared by the LRU page replacement RTL.
`ifndef LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRUP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lrup assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LRUP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lrup assertion failed");

`endif

[src/lrup_pkg.sv]
// Shared widths for the LRU page replacement block.
package lrup_pkg;
  localparam int PAGE_W = 16;
  localparam int CNT_W  = 16;
  localparam int CFG_W  = 4;

  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CFG_W-1:0]  cfg_t;
endpackage

[src/lrup_ifs.sv]
// Valid/ready channel interfaces for the LRU page replacement block.
interface lrup_in_if;
  import lrup_pkg::*;
  logic  valid;
  logic  ready;
  page_t page_number;
  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

interface lrup_out_if;
  import lrup_pkg::*;
  logic  valid;
  logic  ready;
  logic  hit;
  logic  victim_valid;
  page_t victim_page;
  cnt_t  hit_total;
  cnt_t  miss_total;
  modport source (output valid, output hit, output victim_valid, output victim_page,
                  output hit_total, output miss_total, input ready);
  modport sink   (input valid, input hit, input victim_valid, input victim_page,
                  input hit_total, input miss_total, output ready);
endinterface

interface lrup_cfg_if;
  import lrup_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/lru_page_replacement.sv]
// LRU page replacement unit: recency list of resident pages with hit/fault reporting.
//
// One page reference is taken per transfer on in_ch and one result leaves per
// transfer on out_ch. The block sustains one reference per clock cycle while out_ch
// is not stalled. A reference passes the input register, then the result register;
// the rate is set by the single compare-and-shift pass over all FRAMES positions in parallel.
// cfg_ch writes frames_in_use (0 acts as 1, above FRAMES acts as FRAMES); a
// shrink drops the pages beyond the new limit without reporting them. Write the
// register only while no reference is in flight. No clearing pass after reset:
// the list starts empty via per-position valid bits.
`include "lru_page_replacement_assert.svh"

module lru_page_replacement #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  lrup_in_if.sink    in_ch,
  lrup_out_if.source out_ch,
  lrup_cfg_if.sink   cfg_ch
);
  import lrup_pkg::*;

  localparam int LIM_W = $clog2(FRAMES + 1);
  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  typedef logic [PAGE_BITS-1:0] fpage_t;
  typedef logic [LIM_W-1:0]     lim_t;

  // clamp a frame-count write into 1..FRAMES
  function automatic lim_t clamp_frames(input cfg_t v);
    lim_t res;
    if (v == '0) begin
      res = lim_t'(1);
    end else if (int'(v) > FRAMES) begin
      res = lim_t'(FRAMES);
    end else begin
      res = lim_t'(v);
    end
    return res;
  endfunction

  // recency list: position 0 is most recent
  fpage_t            pages_r [FRAMES];
  fpage_t            pages_nxt [FRAMES];
  logic [FRAMES-1:0] valid_r, valid_nxt;
  lim_t              lim_r;
  cnt_t              hit_cnt_r, hit_cnt_nxt;
  cnt_t              miss_cnt_r, miss_cnt_nxt;

  // input stage
  logic   in_v_r;
  fpage_t pg_r;

  // result stage
  logic  out_v_r;
  logic  out_hit_r;
  logic  out_vic_v_r;
  page_t out_vic_pg_r;
  cnt_t  out_hit_tot_r;
  cnt_t  out_miss_tot_r;

  logic advance;   // result register free to take the staged reference
  logic proc;      // staged reference is resolved this cycle
  logic cfg_wr;
  lim_t cfg_lim;

  logic [FRAMES-1:0] match;
  logic [FRAMES-1:0] shift;
  logic [FRAMES-1:0] low_mask;
  logic [FRAMES-1:0] valid_inc;
  logic              hit_w;
  logic              full_w;
  logic [IDX_W-1:0]  tail_idx;
  fpage_t            tail_pg;

  assign advance      = !out_v_r || out_ch.ready;
  assign proc         = in_v_r && advance;
  assign in_ch.ready  = !in_v_r || advance;
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;
  assign cfg_lim      = clamp_frames(cfg_ch.data);

  assign tail_idx = IDX_W'(lim_r - 1'b1);
  assign tail_pg  = pages_r[tail_idx];
  assign full_w   = valid_r[tail_idx];
  assign valid_inc = valid_r + 1'b1;

  always_comb begin
    for (int k = 0; k < FRAMES; k++) begin
      match[k] = valid_r[k] && (k < int'(lim_r)) && (pages_r[k] == pg_r);
    end
    hit_w = |match;

    // position k moves back when it lies at or ahead of the hit (or fill) point
    shift    = '0;
    low_mask = '0;
    shift[0] = 1'b1;
    for (int k = 1; k < FRAMES; k++) begin
      low_mask = ~({FRAMES{1'b1}} << k);
      if (hit_w) begin
        shift[k] = ~|(match & low_mask);
      end else begin
        shift[k] = valid_r[k-1] && (k < int'(lim_r));
      end
    end

    pages_nxt    = pages_r;
    valid_nxt    = valid_r;
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;

    if (cfg_wr) begin
      for (int k = 0; k < FRAMES; k++) begin
        if (k >= int'(cfg_lim)) begin
          valid_nxt[k] = 1'b0;
        end
      end
    end else if (proc) begin
      for (int k = 1; k < FRAMES; k++) begin
        if (shift[k]) begin
          pages_nxt[k] = pages_r[k-1];
          valid_nxt[k] = valid_r[k-1];
        end
      end
      pages_nxt[0] = pg_r;
      valid_nxt[0] = 1'b1;
      if (hit_w) begin
        if (hit_cnt_r != '1) begin
          hit_cnt_nxt = hit_cnt_r + 1'b1;
        end
      end else begin
        if (miss_cnt_r != '1) begin
          miss_cnt_nxt = miss_cnt_r + 1'b1;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      lim_r      <= clamp_frames(cfg_t'(8));
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
      in_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      hit_cnt_r  <= hit_cnt_nxt;
      miss_cnt_r <= miss_cnt_nxt;
      if (cfg_wr) begin
        lim_r <= cfg_lim;
      end
      if (in_ch.ready) begin
        in_v_r <= in_ch.valid;
      end
      if (advance) begin
        out_v_r <= in_v_r;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    pages_r <= pages_nxt;
    if (in_ch.valid && in_ch.ready) begin
      pg_r <= fpage_t'(in_ch.page_number);
    end
    if (proc) begin
      out_hit_r      <= hit_w;
      out_vic_v_r    <= !hit_w && full_w;
      out_vic_pg_r   <= (!hit_w && full_w) ? page_t'(tail_pg) : '0;
      out_hit_tot_r  <= hit_cnt_nxt;
      out_miss_tot_r <= miss_cnt_nxt;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.hit          = out_hit_r;
  assign out_ch.victim_valid = out_vic_v_r;
  assign out_ch.victim_page  = out_vic_pg_r;
  assign out_ch.hit_total    = out_hit_tot_r;
  assign out_ch.miss_total   = out_miss_tot_r;

  // valid positions always form a prefix of the list
  `LRUP_ASSERT_IMP(a_valid_prefix, clk, rst_n, 1'b1, (valid_inc & valid_r) == '0)
  // any resolved reference leaves the front position occupied
  `LRUP_ASSERT_NXT(a_front_valid, clk, rst_n, proc, valid_r[0])
  // a hit never bumps the fault total
  `LRUP_ASSERT_NXT(a_hit_no_miss, clk, rst_n, proc && hit_w, miss_cnt_r == $past(miss_cnt_r))
  // a victim is only reported on a fault
  `LRUP_ASSERT_IMP(a_victim_fault, clk, rst_n, out_v_r && out_vic_v_r, !out_hit_r)

endmodule

[verif/tb_lru_page_replacement.sv]
// Self-checking testbench for the LRU page replacement unit.
module tb_lru_page_replacement;
  timeunit 1ns;
  timeprecision 1ps;

  import lrup_pkg::*;

  localparam int NUM_FRAMES = 8;
  localparam int DRAIN_LIMIT = 20000;   // cycles allowed for outstanding results
  localparam int TAIL_CYCLES = 10;      // idle cycles run after the final drain, as margin

  // One result as the block reports it.
  typedef struct {
    logic  hit;
    logic  victim_valid;
    page_t victim_page;
    cnt_t  hit_total;
    cnt_t  miss_total;
  } lru_outcome_t;

  logic clk;
  logic rst_n;

  lrup_in_if  in_ch();
  lrup_out_if out_ch();
  lrup_cfg_if cfg_ch();

  lru_page_replacement #(
    .FRAMES   (NUM_FRAMES),
    .PAGE_BITS(16)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Shadow copy of the recency list: index 0 is the most recently used page.
  page_t resident_page [NUM_FRAMES];
  bit    resident_valid[NUM_FRAMES];
  cnt_t  hits_so_far;
  cnt_t  misses_so_far;
  cfg_t  frames_reg;

  lru_outcome_t expected_outcomes[$];
  int           error_count;

  // Traffic shaping knobs, percent of cycles spent idle / stalled.
  int sender_idle_pct;
  int sink_stall_pct;

  // Effective frame count: zero behaves as one, anything above the array size saturates.
  function automatic int frames_active();
    int n;
    n = frames_reg;
    if (n == 0) n = 1;
    if (n > NUM_FRAMES) n = NUM_FRAMES;
    return n;
  endfunction

  // Shift positions 0..upto-1 back by one and put pg at the front.
  function automatic void promote(int upto, page_t pg);
    for (int k = upto; k > 0; k--) begin
      resident_page[k]  = resident_page[k-1];
      resident_valid[k] = resident_valid[k-1];
    end
    resident_page[0]  = pg;
    resident_valid[0] = 1'b1;
  endfunction

  // Look up one reference in the shadow list, update it, and return what the block should say.
  function automatic lru_outcome_t lru_access(page_t pg);
    lru_outcome_t r;
    int lim, used, pos;
    bit found;
    r = '{default: '0};
    lim = frames_active();
    used = 0;
    pos = 0;
    found = 1'b0;
    for (int k = 0; k < lim; k++) begin
      if (resident_valid[k]) begin
        used++;
        if (!found && resident_page[k] == pg) begin
          found = 1'b1;
          pos = k;
        end
      end
    end
    if (found) begin
      promote(pos, pg);
      if (hits_so_far != '1) hits_so_far++;
    end else begin
      // List full: the back entry is the victim.
      if (used >= lim) begin
        r.victim_valid = 1'b1;
        r.victim_page  = resident_page[lim-1];
        promote(lim - 1, pg);
      end else begin
        promote(used, pg);
      end
      if (misses_so_far != '1) misses_so_far++;
    end
    r.hit        = found;
    r.hit_total  = hits_so_far;
    r.miss_total = misses_so_far;
    return r;
  endfunction

  // Clock: 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #20_000_000;
    $display("lru_page_replacement regression: fail");
    $finish;
  end

  // Result sink: random backpressure per the current phase.
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Result checker: every transfer on out_ch is matched against the oldest prediction.
  always @(posedge clk) begin
    lru_outcome_t exp;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_outcomes.size() == 0) begin
        $error("unexpected result: hit=%0b victim_valid=%0b victim_page=%h",
               out_ch.hit, out_ch.victim_valid, out_ch.victim_page);
        error_count++;
      end else begin
        exp = expected_outcomes.pop_front();
        if (out_ch.hit !== exp.hit) begin
          $error("hit: expected %0b, got %0b", exp.hit, out_ch.hit);
          error_count++;
        end
        if (out_ch.victim_valid !== exp.victim_valid) begin
          $error("victim_valid: expected %0b, got %0b", exp.victim_valid, out_ch.victim_valid);
          error_count++;
        end
        if (out_ch.victim_page !== exp.victim_page) begin
          $error("victim_page: expected %h, got %h", exp.victim_page, out_ch.victim_page);
          error_count++;
        end
        if (out_ch.hit_total !== exp.hit_total) begin
          $error("hit_total: expected %0d, got %0d", exp.hit_total, out_ch.hit_total);
          error_count++;
        end
        if (out_ch.miss_total !== exp.miss_total) begin
          $error("miss_total: expected %0d, got %0d", exp.miss_total, out_ch.miss_total);
          error_count++;
        end
      end
    end
  end

  // Send one reference; the prediction is queued at the accepting edge.
  task automatic send_page(input page_t pg);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.page_number <= pg;
    do @(posedge clk); while (!in_ch.ready);
    expected_outcomes.push_back(lru_access(pg));
  endtask

  // Stop sending and wait for every outstanding result, bounded.
  task automatic drain_outcomes();
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (expected_outcomes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_outcomes.size() != 0) begin
      $error("%0d results never arrived", expected_outcomes.size());
      error_count += expected_outcomes.size();
      expected_outcomes.delete();
    end
  endtask

  // Register write, only with the pipeline empty. A shrink drops the tail silently.
  task automatic write_frames(input cfg_t value);
    drain_outcomes();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    frames_reg = value;
    for (int k = frames_active(); k < NUM_FRAMES; k++) resident_valid[k] = 1'b0;
  endtask

  // Reset value of eight frames: fill, hit at back/middle/front, then evict.
  task automatic test_fill_and_evict();
    page_t refs[13] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h1234, 16'h5555,
                        16'hAAAA, 16'h00FF, 16'h0000, 16'h1234, 16'h1234, 16'h7777,
                        16'hFFFF};
    foreach (refs[i]) send_page(refs[i]);
  endtask

  // Frame count zero, above range, shrink and grow.
  task automatic test_frame_limits();
    write_frames(4'd0);            // behaves as one frame, keeps only the front page
    send_page(16'hFFFF);           // front page was 0xFFFF -> hit
    send_page(16'h7777);           // miss, evicts 0xFFFF
    send_page(16'h7777);
    write_frames(4'd15);           // saturates to all frames; new slots empty
    send_page(16'h0F0F);           // miss, no victim
    send_page(16'h7777);           // hit at position 1
    send_page(16'hF0F0);
    write_frames(4'd2);            // shrink: third entry dropped without a victim
    send_page(16'h0F0F);           // dropped page -> miss, list full -> victim
    send_page(16'h0F0F);
    write_frames(4'd8);
    send_page(16'h8001);
    send_page(16'h7FFE);
  endtask

  // Mostly a small working set so hits and evictions both happen; some wild pages.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input cfg_t frames, input int count);
    page_t working_set[12];
    page_t pg;
    write_frames(frames);
    sender_idle_pct = idle_pct;
    sink_stall_pct  = stall_pct;
    foreach (working_set[i]) working_set[i] = page_t'($urandom);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) < 8) pg = working_set[$urandom_range(11)];
      else                       pg = page_t'($urandom);
      send_page(pg);
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.page_number = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = '0;
    out_ch.ready      = 1'b0;
    error_count       = 0;
    sender_idle_pct   = 0;
    sink_stall_pct    = 0;
    hits_so_far       = '0;
    misses_so_far     = '0;
    frames_reg        = 4'd8;
    foreach (resident_valid[k]) begin
      resident_valid[k] = 1'b0;
      resident_page[k]  = '0;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_fill_and_evict();
    test_frame_limits();
    test_random_traffic(0, 0, 4'd3, 100);
    test_random_traffic(87, 0, 4'd8, 100);
    test_random_traffic(0, 87, 4'd1, 100);
    test_random_traffic(36, 36, cfg_t'($urandom_range(15)), 100);

    drain_outcomes();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) $display("lru_page_replacement regression: pass");
    else                  $display("lru_page_replacement regression: fail");
    $finish;
  end

endmodule
